// ===== hw/rtl/ifs_pkg.sv =====
// Shared types and constants for the identifier allocator.
// Request and result item layouts, command and status codes, RAM write bundles.
// No dependencies.
`default_nettype none

package ifs_pkg;

	// Pool size and derived widths
	localparam int CAPACITY = 256;
	localparam int ID_W     = 8;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > ID_W) ? CNT_W : ID_W;

	// Command codes
	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_DESTROY = 2'd1;
	localparam logic [1:0] CMD_CHECK   = 2'd2;

	// Status codes
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_EXHAUSTED = 2'd1;
	localparam logic [1:0] STS_INVALID   = 2'd2;

	typedef struct packed {
		logic [1:0]      command;
		logic [ID_W-1:0] entity;
	} ifs_req_t;

	typedef struct packed {
		logic [ID_W-1:0] granted_id;
		logic            is_alive;
		logic [1:0]      status;
	} ifs_rsp_t;

	// Write bundle for the alive-bit RAM
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic              data;
	} ifs_alive_wr_t;

	// Write bundle for the free-stack RAM
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [ID_W-1:0]   data;
	} ifs_stack_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ifs_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`default_nettype none

module ifs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ifs_engine.sv =====
// Command sequencer of the identifier allocator: issues RAM reads on accept,
// then decides, writes back and registers the result. Depends on ifs_pkg.
`default_nettype none

module ifs_engine
	import ifs_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ifs_req_t      request,
	output logic               done,
	output ifs_rsp_t           result,
	output logic [ADDR_W-1:0]  alive_raddr,
	input  wire logic          alive_rdata,
	output logic [ADDR_W-1:0]  stack_raddr,
	input  wire logic [ID_W-1:0] stack_rdata,
	output ifs_alive_wr_t      alive_wr,
	output ifs_stack_wr_t      stack_wr
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t             state_q;
	ifs_req_t           req_q;
	logic [CNT_W-1:0]   next_fresh_q;
	logic [CNT_W-1:0]   free_top_q;
	logic               done_q;
	ifs_rsp_t           result_q;

	logic               accept;
	logic               exec;
	logic [CMP_W-1:0]   ent_w;
	logic               known;
	logic               alive_ok;
	ifs_rsp_t           rsp_d;
	logic [CNT_W-1:0]   next_fresh_d;
	logic [CNT_W-1:0]   free_top_d;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign exec   = (state_q == S_EXEC);
	assign done   = done_q;
	assign result = result_q;

	// Reads are launched from the request ports and the current stack top
	assign alive_raddr = ADDR_W'(request.entity);
	assign stack_raddr = ADDR_W'(free_top_q - CNT_W'(1));

	// Identifier range check: ids below next_fresh have had their alive bit written
	assign ent_w    = CMP_W'(req_q.entity);
	assign known    = (req_q.entity != '0) && (ent_w < CMP_W'(next_fresh_q))
		&& (ent_w < CMP_W'(CAPACITY));
	assign alive_ok = known && alive_rdata;

	// Decide the command and form the write-backs
	always_comb begin
		rsp_d        = '0;
		rsp_d.status = STS_OK;
		next_fresh_d = next_fresh_q;
		free_top_d   = free_top_q;
		alive_wr     = '0;
		stack_wr     = '0;
		case (req_q.command)
			CMD_CREATE: begin
				if (free_top_q != '0) begin
					free_top_d       = free_top_q - CNT_W'(1);
					rsp_d.granted_id = stack_rdata;
					alive_wr.we      = exec;
					alive_wr.addr    = ADDR_W'(stack_rdata);
					alive_wr.data    = 1'b1;
				end else if (CMP_W'(next_fresh_q) < CMP_W'(CAPACITY)) begin
					next_fresh_d     = next_fresh_q + CNT_W'(1);
					rsp_d.granted_id = ID_W'(next_fresh_q);
					alive_wr.we      = exec;
					alive_wr.addr    = ADDR_W'(next_fresh_q);
					alive_wr.data    = 1'b1;
				end else begin
					rsp_d.status = STS_EXHAUSTED;
				end
			end
			CMD_DESTROY: begin
				if (alive_ok) begin
					alive_wr.we   = exec;
					alive_wr.addr = ADDR_W'(req_q.entity);
					alive_wr.data = 1'b0;
					if (CMP_W'(free_top_q) < CMP_W'(CAPACITY)) begin
						stack_wr.we   = exec;
						stack_wr.addr = ADDR_W'(free_top_q);
						stack_wr.data = req_q.entity;
						free_top_d    = free_top_q + CNT_W'(1);
					end
				end else begin
					rsp_d.status = STS_INVALID;
				end
			end
			CMD_CHECK: begin
				if (alive_ok) begin
					rsp_d.is_alive = 1'b1;
				end else begin
					rsp_d.status = STS_INVALID;
				end
			end
			default: begin
				rsp_d.status = STS_INVALID;
			end
		endcase
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			next_fresh_q <= CNT_W'(1);
			free_top_q   <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					next_fresh_q <= next_fresh_d;
					free_top_q   <= free_top_d;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (exec) begin
			result_q <= rsp_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/id_allocator_free_stack.sv =====
// Top level of the identifier allocator with a LIFO free stack.
// Depends on ifs_pkg, ifs_ram and ifs_engine.
//
// Usage:
//   Input channel: drive request (command, entity) with start high; the item
//   is accepted at a rising edge where start is high and busy is low.
//   Commands: create hands out a freed id (most recent first) or a fresh one,
//   destroy frees a live id, check reports whether an id is alive.
//   Identifier 0 means none and is never handed out.
//   Output channel: done strobes for one cycle with result valid in that cycle.
//   The receiver cannot stall; every result must be taken when done is high.
//   The accepting edge registers the alive-bit and free-stack RAM reads, and
//   the result and done are registered at the end of the write-back cycle.
//   A new item is not accepted until the item before it has been written back.
//   busy is high during the write-back cycle, so reads of an item always see
//   the writes of the item before it.
//   Reset: all ids dead, free stack empty, next fresh id 1. No clearing pass;
//   an alive bit is only read for ids already handed out, which were written.
`default_nettype none

module id_allocator_free_stack
	import ifs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire ifs_req_t request,
	output logic          done,
	output ifs_rsp_t      result
);

	logic [ADDR_W-1:0] alive_raddr;
	logic              alive_rdata;
	logic [ADDR_W-1:0] stack_raddr;
	logic [ID_W-1:0]   stack_rdata;
	ifs_alive_wr_t     alive_wr;
	ifs_stack_wr_t     stack_wr;

	// Sequencer
	ifs_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.done        (done),
		.result      (result),
		.alive_raddr (alive_raddr),
		.alive_rdata (alive_rdata),
		.stack_raddr (stack_raddr),
		.stack_rdata (stack_rdata),
		.alive_wr    (alive_wr),
		.stack_wr    (stack_wr)
	);

	// Alive bit per identifier
	ifs_ram #(
		.WIDTH (1),
		.DEPTH (CAPACITY)
	) u_alive_ram (
		.clk   (clk),
		.we    (alive_wr.we),
		.waddr (alive_wr.addr),
		.wdata (alive_wr.data),
		.raddr (alive_raddr),
		.rdata (alive_rdata)
	);

	// Free stack of released identifiers
	ifs_ram #(
		.WIDTH (ID_W),
		.DEPTH (CAPACITY)
	) u_stack_ram (
		.clk   (clk),
		.we    (stack_wr.we),
		.waddr (stack_wr.addr),
		.wdata (stack_wr.data),
		.raddr (stack_raddr),
		.rdata (stack_rdata)
	);

endmodule

`default_nettype wire
